/* rtl/core/sparse_image_run_chunker_core_macros.svh */
// assertion macros used by the chunker back end
`ifndef SPARSE_IMAGE_RUN_CHUNKER_CORE_MACROS_SVH
`define SPARSE_IMAGE_RUN_CHUNKER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SIRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sirc_pkg.sv */
`timescale 1ns / 1ps

package sirc_pkg;

  // image geometry and run limits
  localparam int BLOCK_WORDS = 256;
  localparam int MAX_RUN     = 65535;
  localparam int POS_W       = $clog2(BLOCK_WORDS);

  // chunk sizing
  localparam int HDR_BYTES   = 12;
  localparam int FILL_BYTES  = 16;
  localparam int BYTES_W     = 26;
  localparam int BYTES_MAX   = (1 << BYTES_W) - 1;
  localparam int COUNT_W     = 16;
  localparam int WORD_W      = 32;

  // queue sizes
  localparam int BQ_DEPTH    = 2;
  localparam int BQ_PTR_W    = 1;
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_W    = 2;

  // chunk kinds
  localparam logic KIND_RAW  = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  // one finished block as seen by the back end
  typedef struct packed {
    logic              fill;
    logic [WORD_W-1:0] fword;
    logic              eoi;
  } block_desc_t;

  // one chunk descriptor
  typedef struct packed {
    logic               kind;
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  fill_value;
    logic [BYTES_W-1:0] bytes;
    logic               final_of_item;
    logic               image_done;
  } chunk_t;

endpackage

/* rtl/core/sirc_front.sv */
`timescale 1ns / 1ps

module sirc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [sirc_pkg::WORD_W-1:0] data_word,
  input  logic                      end_of_image,
  output logic                      desc_push,
  output sirc_pkg::block_desc_t     desc
);
  import sirc_pkg::*;

  logic [POS_W-1:0]  word_position;
  logic [WORD_W-1:0] block_first_word;
  logic              block_uniform;

  logic              at_first;
  logic              at_last;
  logic [WORD_W-1:0] first_now;
  logic              uniform_now;

  // classify the word against the block's first word
  always_comb begin
    at_first    = (word_position == '0);
    at_last     = (word_position == POS_W'(BLOCK_WORDS - 1));
    first_now   = at_first ? data_word : block_first_word;
    uniform_now = at_first ? 1'b1 : (block_uniform && (data_word == block_first_word));
  end

  // descriptor of a completed block
  always_comb begin
    desc_push  = accept && at_last;
    desc.fill  = uniform_now;
    desc.fword = uniform_now ? first_now : '0;
    desc.eoi   = end_of_image;
  end

  // block position and running uniformity
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position    <= '0;
      block_first_word <= '0;
      block_uniform    <= 1'b1;
    end else if (accept) begin
      if (at_last) begin
        word_position <= '0;
        block_uniform <= 1'b1;
      end else begin
        word_position <= word_position + POS_W'(1);
        block_uniform <= uniform_now;
      end
      block_first_word <= first_now;
    end
  end

endmodule

/* rtl/core/sirc_blk_queue.sv */
`timescale 1ns / 1ps

module sirc_blk_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  sirc_pkg::block_desc_t wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output logic                  rd_valid,
  output sirc_pkg::block_desc_t rd_data
);
  import sirc_pkg::*;

  block_desc_t         slot [BQ_DEPTH];
  logic [BQ_PTR_W-1:0] wr_ptr;
  logic [BQ_PTR_W-1:0] rd_ptr;
  logic [BQ_PTR_W:0]   count;

  // status and head
  always_comb begin
    full     = (count == (BQ_PTR_W + 1)'(BQ_DEPTH));
    rd_valid = (count != '0);
    rd_data  = slot[rd_ptr];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + BQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + BQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (BQ_PTR_W + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (BQ_PTR_W + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/sirc_out_queue.sv */
`timescale 1ns / 1ps

module sirc_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  sirc_pkg::chunk_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             empty,
  output sirc_pkg::chunk_t rd_data
);
  import sirc_pkg::*;

  chunk_t              slot [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_PTR_W:0]   count;

  // status and head
  always_comb begin
    full    = (count == (OQ_PTR_W + 1)'(OQ_DEPTH));
    empty   = (count == '0);
    rd_data = slot[rd_ptr];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (OQ_PTR_W + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (OQ_PTR_W + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/sirc_back.sv */
`timescale 1ns / 1ps

`include "sparse_image_run_chunker_core_macros.svh"

module sirc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  desc_valid,
  input  sirc_pkg::block_desc_t desc,
  output logic                  desc_pop,
  input  logic                  out_full,
  output logic                  out_push,
  output sirc_pkg::chunk_t      out_chunk
);
  import sirc_pkg::*;

  logic               run_open;
  logic               run_is_fill;
  logic [WORD_W-1:0]  run_fill_word;
  logic [COUNT_W-1:0] run_length;

  logic               busy;
  logic               brk;
  logic               close_new;
  logic [COUNT_W-1:0] new_len;
  logic               brk_push;

  // build one chunk descriptor from run fields
  function automatic chunk_t make_chunk(input logic is_fill, input logic [WORD_W-1:0] fword,
                                        input logic [COUNT_W-1:0] len, input logic fin,
                                        input logic done);
    chunk_t     c;
    logic [31:0] raw_bytes;
    raw_bytes = 32'(len) * 32'(BLOCK_WORDS * 4) + 32'(HDR_BYTES);
    c.kind          = is_fill ? KIND_FILL : KIND_RAW;
    c.count         = len;
    c.fill_value    = is_fill ? fword : '0;
    if (is_fill) begin
      c.bytes = BYTES_W'(FILL_BYTES);
    end else if (raw_bytes > 32'(BYTES_MAX)) begin
      c.bytes = BYTES_W'(BYTES_MAX);
    end else begin
      c.bytes = raw_bytes[BYTES_W-1:0];
    end
    c.final_of_item = fin;
    c.image_done    = done;
    return c;
  endfunction

  // decide what the head block does to the open run
  always_comb begin
    busy      = desc_valid && !out_full;
    brk       = run_open && ((run_is_fill != desc.fill) ||
                             (desc.fill && (run_fill_word != desc.fword)));
    new_len   = run_open ? (run_length + COUNT_W'(1)) : COUNT_W'(1);
    close_new = (32'(new_len) >= 32'(MAX_RUN)) || desc.eoi;
    brk_push  = busy && brk;
    desc_pop  = busy && !brk;
    out_push  = brk_push || (desc_pop && close_new);
    if (brk) begin
      // broken run goes out first; the new run of length one opens once the head block is popped
      out_chunk = make_chunk(run_is_fill, run_fill_word, run_length,
                             !((1 >= MAX_RUN) || desc.eoi), 1'b0);
    end else begin
      out_chunk = make_chunk(desc.fill, desc.fword, new_len, 1'b1, desc.eoi);
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open      <= 1'b0;
      run_is_fill   <= 1'b0;
      run_fill_word <= '0;
      run_length    <= '0;
    end else if (brk_push) begin
      run_open   <= 1'b0;
      run_length <= '0;
    end else if (desc_pop) begin
      if (close_new) begin
        run_open      <= 1'b0;
        run_is_fill   <= 1'b0;
        run_fill_word <= '0;
        run_length    <= '0;
      end else begin
        run_open      <= 1'b1;
        run_is_fill   <= desc.fill;
        run_fill_word <= desc.fword;
        run_length    <= new_len;
      end
    end
  end

  // checks on run bookkeeping
  `SIRC_ASSERT_NOW(a_open_len, 1'b1, run_open == (run_length != '0), "run_open and length disagree")
  `SIRC_ASSERT_NOW(a_len_max, 1'b1, 32'(run_length) < 32'(MAX_RUN), "open run reached limit")
  `SIRC_ASSERT_NOW(a_done_final, out_push && out_chunk.image_done, out_chunk.final_of_item, "image end chunk not final")
  `SIRC_ASSERT_NEXT(a_brk_closes, brk_push, !run_open, "run still open after break")

endmodule

/* rtl/core/sparse_image_run_chunker_core.sv */
`timescale 1ns / 1ps

// a block's chunk reaches the result ports through the block queue and the result queue;
//   when the block first closes a run of another kind, the broken run's chunk goes out first
// throughput: one word per cycle while full is low; the back end handles each block and
//   each run break while the next block's words still arrive
// reset: synchronous, clears block position, run state and both queues
module sparse_image_run_chunker_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [31:0]                   data_word,
  input  logic                          end_of_image,
  output logic                          empty,
  input  logic                          pop,
  output logic                          chunk_kind,
  output logic [15:0]                   block_count,
  output logic [31:0]                   fill_value,
  output logic [25:0]                   chunk_bytes,
  output logic                          final_of_item,
  output logic                          image_done
);
  import sirc_pkg::*;

  logic        accept;
  logic        desc_push;
  block_desc_t desc_in;
  logic        bq_full;
  logic        desc_pop;
  logic        desc_valid;
  block_desc_t desc_head;
  logic        out_push;
  chunk_t      out_chunk;
  logic        oq_full;
  chunk_t      head;

  // input handshake
  assign full   = bq_full;
  assign accept = push && !full;

  // front: block classification
  sirc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_word    (data_word),
    .end_of_image (end_of_image),
    .desc_push    (desc_push),
    .desc         (desc_in)
  );

  // queue of finished blocks
  sirc_blk_queue u_blk_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (desc_push),
    .wr_data  (desc_in),
    .full     (bq_full),
    .rd_en    (desc_pop),
    .rd_valid (desc_valid),
    .rd_data  (desc_head)
  );

  // back: run tracking and chunk emission
  sirc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc_head),
    .desc_pop   (desc_pop),
    .out_full   (oq_full),
    .out_push   (out_push),
    .out_chunk  (out_chunk)
  );

  // result queue
  sirc_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_chunk),
    .full    (oq_full),
    .rd_en   (pop && !empty),
    .empty   (empty),
    .rd_data (head)
  );

  // result fields
  assign chunk_kind    = head.kind;
  assign block_count   = head.count;
  assign fill_value    = head.fill_value;
  assign chunk_bytes   = head.bytes;
  assign final_of_item = head.final_of_item;
  assign image_done    = head.image_done;

endmodule

/* tb/sparse_image_run_chunker_core_test.sv */
`timescale 1ns / 1ps

module sparse_image_run_chunker_core_test;
  import sirc_pkg::*;

  typedef enum int {SHAPE_FILL, SHAPE_ODD, SHAPE_NOISE} shape_t;

  // one image block of stimulus, with optional hand-written chunks
  typedef struct {
    shape_t      shape;
    logic [31:0] base;
    int          odd_idx;
    logic [31:0] odd_word;
    logic        eoi;
    int          eoi_ignored_idx;
    bit          typed;
    int          n_typed;
    chunk_t      c0;
    chunk_t      c1;
  } block_row_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        push         = 1'b0;
  logic [31:0] data_word    = '0;
  logic        end_of_image = 1'b0;
  logic        pop          = 1'b0;
  logic        full;
  logic        empty;
  logic        chunk_kind;
  logic [15:0] block_count;
  logic [31:0] fill_value;
  logic [25:0] chunk_bytes;
  logic        final_of_item;
  logic        image_done;

  chunk_t      chunks_due[$];
  block_row_t  directed_blocks[$];
  int          mismatch_count   = 0;
  int          chunks_predicted = 0;
  int          idle_pct         = 0;
  int          stall_pct        = 0;
  logic [31:0] fill_pool [3]    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hDEAD_BEEF};

  // predicted block and run state
  logic [POS_W-1:0] pos_in_block = '0;
  logic [31:0]      block_head   = '0;
  logic             block_flat   = 1'b1;
  logic             run_active   = 1'b0;
  logic             run_fill     = 1'b0;
  logic [31:0]      run_word     = '0;
  int               run_blocks   = 0;

  sparse_image_run_chunker_core dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_word     (data_word),
    .end_of_image  (end_of_image),
    .empty         (empty),
    .pop           (pop),
    .chunk_kind    (chunk_kind),
    .block_count   (block_count),
    .fill_value    (fill_value),
    .chunk_bytes   (chunk_bytes),
    .final_of_item (final_of_item),
    .image_done    (image_done)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  function automatic chunk_t chunk_of(input logic kind, input int blocks, input logic [31:0] fv,
                                      input int nbytes, input logic fin, input logic done);
    chunk_t c;
    c.kind          = kind;
    c.count         = COUNT_W'(blocks);
    c.fill_value    = fv;
    c.bytes         = BYTES_W'(nbytes);
    c.final_of_item = fin;
    c.image_done    = done;
    return c;
  endfunction

  // descriptor for the run now open
  function automatic chunk_t chunk_of_run(input logic done);
    chunk_t c;
    longint nbytes;
    nbytes = longint'(run_blocks) * BLOCK_WORDS * 4 + HDR_BYTES;
    if (nbytes > BYTES_MAX) begin
      nbytes = BYTES_MAX;
    end
    c.kind          = run_fill ? KIND_FILL : KIND_RAW;
    c.count         = COUNT_W'(run_blocks);
    c.fill_value    = run_fill ? run_word : '0;
    c.bytes         = run_fill ? BYTES_W'(FILL_BYTES) : BYTES_W'(nbytes);
    c.final_of_item = 1'b0;
    c.image_done    = done;
    return c;
  endfunction

  // chunks closed by one image word, at most two
  function automatic int run_chunks_for_word(input logic [31:0] w, input logic e,
                                             output chunk_t r0, output chunk_t r1);
    int          n;
    logic        fill;
    logic [31:0] fw;
    chunk_t      c;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (pos_in_block == 0) begin
      block_head = w;
      block_flat = 1'b1;
    end else if (w != block_head) begin
      block_flat = 1'b0;
    end
    if (int'(pos_in_block) != BLOCK_WORDS - 1) begin
      pos_in_block++;
      return 0;
    end
    pos_in_block = '0;
    fill = block_flat;
    fw   = fill ? block_head : '0;
    block_flat = 1'b1;
    // run break on kind or fill word change
    if (run_active && (run_fill != fill || (fill && run_word != fw))) begin
      r0 = chunk_of_run(1'b0);
      n = 1;
      run_active = 1'b0;
    end
    if (run_active) begin
      run_blocks++;
    end else begin
      run_active = 1'b1;
      run_fill   = fill;
      run_word   = fw;
      run_blocks = 1;
    end
    // full run or image end
    if (run_blocks >= MAX_RUN || e) begin
      c = chunk_of_run(e);
      if (n == 0) begin
        r0 = c;
      end else begin
        r1 = c;
      end
      n++;
      run_active = 1'b0;
      run_fill   = 1'b0;
      run_word   = '0;
      run_blocks = 0;
    end
    if (e) begin
      block_head = '0;
    end
    if (n == 1) begin
      r0.final_of_item = 1'b1;
    end else if (n == 2) begin
      r1.final_of_item = 1'b1;
    end
    return n;
  endfunction

  function automatic block_row_t blk(input shape_t shape, input logic [31:0] base,
                                     input int odd_idx, input logic [31:0] odd_word,
                                     input logic eoi, input int ign, input int n_typed,
                                     input chunk_t c0, input chunk_t c1);
    block_row_t b;
    b.shape           = shape;
    b.base            = base;
    b.odd_idx         = odd_idx;
    b.odd_word        = odd_word;
    b.eoi             = eoi;
    b.eoi_ignored_idx = ign;
    b.typed           = (n_typed >= 0);
    b.n_typed         = n_typed;
    b.c0              = c0;
    b.c1              = c1;
    return b;
  endfunction

  // random block, biased toward runs of a few fill words
  function automatic block_row_t random_block();
    block_row_t b;
    int         r;
    r = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      fill_pool[$urandom_range(2)] = $urandom;
    end
    b.shape           = (r < 45) ? SHAPE_FILL : (r < 85) ? SHAPE_ODD : SHAPE_NOISE;
    b.base            = fill_pool[$urandom_range(2)];
    b.odd_idx         = $urandom_range(BLOCK_WORDS - 1);
    b.odd_word        = $urandom_range(1) ? (b.base ^ (32'd1 << $urandom_range(31))) : $urandom;
    b.eoi             = ($urandom_range(3) == 0);
    b.eoi_ignored_idx = ($urandom_range(7) == 0) ? int'($urandom_range(BLOCK_WORDS - 2)) : -1;
    b.typed           = 1'b0;
    b.n_typed         = 0;
    b.c0              = '0;
    b.c1              = '0;
    return b;
  endfunction

  // one item per call, with random sender gaps
  task automatic send_word(input logic [31:0] w, input logic e, input bit typed);
    chunk_t r0;
    chunk_t r1;
    int     n;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    data_word    <= w;
    end_of_image <= e;
    do @(posedge clk); while (full);
    n = run_chunks_for_word(w, e, r0, r1);
    chunks_predicted += n;
    if (!typed) begin
      if (n > 0) chunks_due.push_back(r0);
      if (n > 1) chunks_due.push_back(r1);
    end
  endtask

  task automatic send_block(input block_row_t b, input int n_words);
    logic [31:0] w;
    logic        e;
    for (int idx = 0; idx < n_words; idx++) begin
      if (b.shape == SHAPE_NOISE) begin
        w = $urandom;
      end else if (b.shape == SHAPE_ODD && idx == b.odd_idx) begin
        w = b.odd_word;
      end else begin
        w = b.base;
      end
      e = (idx == BLOCK_WORDS - 1) ? b.eoi : (idx == b.eoi_ignored_idx);
      send_word(w, e, b.typed);
    end
    if (b.typed) begin
      if (b.n_typed > 0) chunks_due.push_back(b.c0);
      if (b.n_typed > 1) chunks_due.push_back(b.c1);
    end
  endtask

  // result side: random stalls, compare against oldest expected chunk
  initial begin
    chunk_t want;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (chunks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected chunk kind %0d count %0d fill %h bytes %0d",
                                    chunk_kind, block_count, fill_value, chunk_bytes));
        end else begin
          want = chunks_due.pop_front();
          if (chunk_kind !== want.kind)
            report_mismatch($sformatf("chunk_kind got %0d want %0d", chunk_kind, want.kind));
          if (block_count !== want.count)
            report_mismatch($sformatf("block_count got %0d want %0d", block_count, want.count));
          if (fill_value !== want.fill_value)
            report_mismatch($sformatf("fill_value got %h want %h", fill_value, want.fill_value));
          if (chunk_bytes !== want.bytes)
            report_mismatch($sformatf("chunk_bytes got %0d want %0d", chunk_bytes, want.bytes));
          if (final_of_item !== want.final_of_item)
            report_mismatch($sformatf("final_of_item got %0d want %0d",
                                      final_of_item, want.final_of_item));
          if (image_done !== want.image_done)
            report_mismatch($sformatf("image_done got %0d want %0d", image_done, want.image_done));
        end
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // stimulus
  initial begin
    block_row_t b;
    int         start;
    int         waited;

    // directed blocks: fill after reset, run breaks, image end, ignored end flags
    directed_blocks.push_back(blk(SHAPE_FILL, 32'h0000_0000, 0, '0, 1'b1, -1, 1,
      chunk_of(KIND_FILL, 1, 32'h0000_0000, FILL_BYTES, 1'b1, 1'b1), '0));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'hFFFF_FFFF, 0, '0, 1'b0, -1, 0, '0, '0));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'hFFFF_FFFF, 0, '0, 1'b0, -1, -1, '0, '0));
    directed_blocks.push_back(blk(SHAPE_ODD, 32'hFFFF_FFFF, BLOCK_WORDS - 1, 32'h0, 1'b0, -1, 1,
      chunk_of(KIND_FILL, 2, 32'hFFFF_FFFF, FILL_BYTES, 1'b1, 1'b0), '0));
    directed_blocks.push_back(blk(SHAPE_ODD, 32'h0000_0000, 0, 32'hFFFF_FFFF, 1'b1, -1, 1,
      chunk_of(KIND_RAW, 2, 32'h0, 2 * BLOCK_WORDS * 4 + HDR_BYTES, 1'b1, 1'b1), '0));
    directed_blocks.push_back(blk(SHAPE_NOISE, 32'h0, 0, '0, 1'b0, 100, -1, '0, '0));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'h1234_5678, 0, '0, 1'b1, -1, 2,
      chunk_of(KIND_RAW, 1, 32'h0, BLOCK_WORDS * 4 + HDR_BYTES, 1'b0, 1'b0),
      chunk_of(KIND_FILL, 1, 32'h1234_5678, FILL_BYTES, 1'b1, 1'b1)));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'hA5A5_A5A5, 0, '0, 1'b0, -1, -1, '0, '0));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'h5A5A_5A5A, 0, '0, 1'b0, -1, -1, '0, '0));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'h5A5A_5A5A, 0, '0, 1'b1, -1, -1, '0, '0));
    directed_blocks.push_back(blk(SHAPE_ODD, 32'h8000_0000, 128, 32'h8000_0001, 1'b0, -1, -1,
      '0, '0));
    directed_blocks.push_back(blk(SHAPE_ODD, 32'h7FFF_FFFF, 200, 32'hFFFF_FFFF, 1'b1, -1, -1,
      '0, '0));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'h0000_0001, 0, '0, 1'b0, 0, -1, '0, '0));
    directed_blocks.push_back(blk(SHAPE_FILL, 32'h0000_0001, 0, '0, 1'b1, -1, -1, '0, '0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_blocks[i]) begin
      send_block(directed_blocks[i], BLOCK_WORDS);
    end

    // random blocks under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 49;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 49;
        end
        default: begin
          idle_pct  = 9;
          stall_pct = 9;
        end
      endcase
      start = chunks_predicted;
      while (chunks_predicted - start < 12) begin
        b = random_block();
        send_block(b, BLOCK_WORDS);
      end
    end

    // unfinished block at the tail, with an end flag that must be ignored
    b = random_block();
    b.shape = SHAPE_NOISE;
    b.eoi_ignored_idx = 0;
    send_block(b, $urandom_range(1, BLOCK_WORDS - 1));
    push         <= 1'b0;
    end_of_image <= 1'b0;

    // drain
    waited = 0;
    while (chunks_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (chunks_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected chunks never arrived", chunks_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sirc_pkg.sv
rtl/core/sirc_front.sv
rtl/core/sirc_blk_queue.sv
rtl/core/sirc_out_queue.sv
rtl/core/sirc_back.sv
rtl/core/sparse_image_run_chunker_core.sv
tb/sparse_image_run_chunker_core_test.sv
